[hdl/hcc_pkg.sv]
package hcc_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
  localparam int LEAF_IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int NODE_IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int NODE_WT_W   = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int CODE_W      = 31;
  localparam int LEN_W       = 5;
  localparam int SYM_W       = 8;
  localparam int IN_WT_W     = 16;
  localparam int STATUS_W    = 3;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_INVALID   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_CODE,
    RES_SYM,
    RES_UNKNOWN,
    RES_INVALID,
    RES_FULL,
    RES_NOT_BUILT
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LK_RD,
    S_LK_CHK,
    S_LD_END,
    S_BLD_INIT,
    S_SC_RD,
    S_SC_CHK,
    S_POP,
    S_ASG_ROOT,
    S_ASG_RD,
    S_ASG_C0,
    S_ASG_C1,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      idx_inc;
    logic      idx_dec;
    logic      scan_chk;
    logic      lk_chk;
    logic      ld_update;
    logic      ld_append;
    logic      bld_init;
    logic      pop;
    logic      asg_root;
    logic      asg_c0;
    logic      asg_c1;
    logic      bld_finish;
    logic      acc_clr;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_push;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic built;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic leaf_last;
    logic lk_match;
    logic prefix_any;
    logic node_last;
    logic first;
    logic merge_last;
    logic asg_last;
    logic out_free;
  } stat_t;

endpackage

[hdl/hcc_datapath.sv]
module hcc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  hcc_pkg::cmd_t                 cmd,
  output hcc_pkg::stat_t                stat,
  input  logic [hcc_pkg::IN_DATA_W-1:0] in_data,
  input  logic [1:0]                    in_user,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hcc_pkg::OUT_DATA_W-1:0] out_data
);
  import hcc_pkg::*;

  localparam int ENTRY_W = LEN_W + CODE_W;

  // Stores, each with one write port and a registered read at idx.
  logic [SYM_W-1:0]          leaf_mem [MAX_SYMBOLS];
  logic [NODE_WT_W-1:0]      wt_mem   [NODE_COUNT];
  logic [2*NODE_IDX_W-1:0]   ch_mem   [NODE_COUNT];
  logic [ENTRY_W-1:0]        code_mem [NODE_COUNT];

  logic [SYM_W-1:0]          leaf_rd;
  logic [NODE_WT_W-1:0]      wt_rd;
  logic [2*NODE_IDX_W-1:0]   ch_rd;
  logic [ENTRY_W-1:0]        code_rd;

  logic [CNT_W-1:0]          count;
  logic                      built;
  logic [CODE_W-1:0]         acc;
  logic [LEN_W-1:0]          acc_len;
  logic [NODE_IDX_W-1:0]     idx;
  logic [NODE_IDX_W-1:0]     total;
  logic                      found;
  logic                      first;
  logic                      prefix;
  logic [NODE_COUNT-1:0]     live;

  op_t                       op_r;
  logic [SYM_W-1:0]          sym_r;
  logic [IN_WT_W-1:0]        w_r;
  logic [NODE_IDX_W-1:0]     best;
  logic [NODE_WT_W-1:0]      best_w;
  logic [NODE_IDX_W-1:0]     p;
  logic [NODE_WT_W-1:0]      pw;

  logic [STATUS_W-1:0]       res_status;
  logic [SYM_W-1:0]          res_sym;
  logic [CODE_W-1:0]         res_code;
  logic [LEN_W-1:0]          res_len;

  logic [CODE_W-1:0]         rd_code;
  logic [LEN_W-1:0]          rd_len;
  logic [LEN_W-1:0]          shamt;
  logic                      take;
  logic                      cur_prefix;
  logic                      exact;

  logic                      wt_we;
  logic [NODE_IDX_W-1:0]     wt_wa;
  logic [NODE_WT_W-1:0]      wt_wd;
  logic                      code_we;
  logic [NODE_IDX_W-1:0]     code_wa;
  logic [ENTRY_W-1:0]        code_wd;
  logic [2*CNT_W-1:0]        unused_wide;
  logic [CNT_W:0]            two_n_minus_two;

  assign rd_code    = code_rd[CODE_W-1:0];
  assign rd_len     = code_rd[ENTRY_W-1:CODE_W];
  assign shamt      = rd_len - acc_len;
  assign take       = live[idx] && (!found || (wt_rd < best_w));
  assign exact      = (rd_len == acc_len) && (rd_code == acc);
  assign cur_prefix = (rd_len > acc_len) && ((rd_code >> shamt) == acc);
  assign unused_wide = '0;
  assign two_n_minus_two = {count, 1'b0} - (CNT_W+1)'(2);

  always_comb begin
    stat.op         = op_r;
    stat.built      = built;
    stat.cnt_zero   = (count == '0);
    stat.cnt_one    = (count == CNT_W'(1));
    stat.cnt_full   = (count == CNT_W'(MAX_SYMBOLS));
    stat.leaf_last  = (idx == NODE_IDX_W'(count - CNT_W'(1)));
    stat.lk_match   = (op_r == OP_DECODE) ? exact : (leaf_rd == sym_r);
    stat.prefix_any = prefix || cur_prefix;
    stat.node_last  = (idx == total - NODE_IDX_W'(1));
    stat.first      = first;
    stat.merge_last = ({1'b0, total} == two_n_minus_two);
    stat.asg_last   = (idx == NODE_IDX_W'(count));
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    wt_we = 1'b0;
    wt_wa = idx;
    wt_wd = NODE_WT_W'(w_r[WEIGHT_BITS-1:0]);
    if (cmd.ld_update) begin
      wt_we = 1'b1;
    end else if (cmd.ld_append) begin
      wt_we = 1'b1;
      wt_wa = NODE_IDX_W'(count);
    end else if (cmd.pop && !first) begin
      wt_we = 1'b1;
      wt_wa = total;
      wt_wd = pw + best_w;
    end
  end

  always_comb begin
    code_we = 1'b0;
    code_wa = ch_rd[NODE_IDX_W-1:0];
    code_wd = {rd_len + LEN_W'(1), rd_code[CODE_W-2:0], 1'b0};
    if (cmd.asg_root) begin
      code_we = 1'b1;
      code_wa = total - NODE_IDX_W'(1);
      code_wd = '0;
    end else if (cmd.asg_c0) begin
      code_we = 1'b1;
    end else if (cmd.asg_c1) begin
      code_we = 1'b1;
      code_wa = ch_rd[2*NODE_IDX_W-1:NODE_IDX_W];
      code_wd = {rd_len + LEN_W'(1), rd_code[CODE_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    leaf_rd <= leaf_mem[idx[LEAF_IDX_W-1:0]];
    wt_rd   <= wt_mem[idx];
    ch_rd   <= ch_mem[idx];
    code_rd <= code_mem[idx];
    if (cmd.ld_append) begin
      leaf_mem[count[LEAF_IDX_W-1:0]] <= sym_r;
    end
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    if (cmd.pop && !first) begin
      ch_mem[total] <= {best, p};
    end
    if (code_we) begin
      code_mem[code_wa] <= code_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      built     <= 1'b0;
      acc       <= '0;
      acc_len   <= '0;
      idx       <= '0;
      total     <= '0;
      found     <= 1'b0;
      first     <= 1'b1;
      prefix    <= 1'b0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        idx    <= '0;
        found  <= 1'b0;
        prefix <= 1'b0;
        if ((op_t'(in_user) == OP_DECODE) && built) begin
          acc     <= {acc[CODE_W-2:0], in_data[SYM_W+IN_WT_W]};
          acc_len <= acc_len + LEN_W'(1);
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + NODE_IDX_W'(1);
      end
      if (cmd.idx_dec) begin
        idx <= idx - NODE_IDX_W'(1);
      end
      if (cmd.scan_chk && take) begin
        found <= 1'b1;
      end
      if (cmd.lk_chk && cur_prefix) begin
        prefix <= 1'b1;
      end
      if (cmd.ld_update || cmd.ld_append) begin
        built   <= 1'b0;
        acc     <= '0;
        acc_len <= '0;
      end
      if (cmd.ld_append) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.bld_init) begin
        for (int i = 0; i < NODE_COUNT; i++) begin
          live[i] <= (i < int'(count));
        end
        total <= NODE_IDX_W'(count);
        idx   <= '0;
        found <= 1'b0;
        first <= 1'b1;
      end
      if (cmd.pop) begin
        live[best] <= 1'b0;
        idx        <= '0;
        found      <= 1'b0;
        first      <= !first;
        if (!first) begin
          live[total] <= 1'b1;
          total       <= total + NODE_IDX_W'(1);
        end
      end
      if (cmd.asg_root) begin
        idx <= total - NODE_IDX_W'(1);
      end
      if (cmd.bld_finish || cmd.acc_clr) begin
        acc     <= '0;
        acc_len <= '0;
      end
      if (cmd.bld_finish) begin
        built <= 1'b1;
      end
      if (cmd.out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_user);
      sym_r <= in_data[SYM_W-1:0];
      w_r   <= in_data[SYM_W+IN_WT_W-1:SYM_W];
    end
    if (cmd.scan_chk && take) begin
      best   <= idx;
      best_w <= wt_rd;
    end
    if (cmd.pop && first) begin
      p  <= best;
      pw <= best_w;
    end
    if (cmd.res_load) begin
      res_status <= ST_OK;
      res_sym    <= '0;
      res_code   <= '0;
      res_len    <= '0;
      unique case (cmd.res_kind)
        RES_OK:        res_status <= ST_OK;
        RES_CODE: begin
          res_code <= rd_code;
          res_len  <= rd_len;
        end
        RES_SYM:       res_sym    <= leaf_rd;
        RES_UNKNOWN:   res_status <= ST_UNKNOWN;
        RES_INVALID:   res_status <= ST_INVALID;
        RES_FULL:      res_status <= ST_FULL;
        RES_NOT_BUILT: res_status <= ST_NOT_BUILT;
        default:       res_status <= ST_OK;
      endcase
    end
    if (cmd.out_push) begin
      out_data <= {1'b0, res_len, res_code, res_sym, res_status}
                  | OUT_DATA_W'(unused_wide);
    end
  end

endmodule

[hdl/hcc_ctrl.sv]
module hcc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcc_pkg::stat_t stat,
  output hcc_pkg::cmd_t  cmd
);
  import hcc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.op)
          OP_LOAD:  state_next = stat.cnt_zero ? S_LD_END : S_LK_RD;
          OP_BUILD: state_next = stat.cnt_zero ? S_DONE : S_BLD_INIT;
          default:  state_next = stat.built ? S_LK_RD : S_DONE;
        endcase
      end
      S_LK_RD:    state_next = S_LK_CHK;
      S_LK_CHK: begin
        if (stat.lk_match) begin
          state_next = S_DONE;
        end else if (stat.leaf_last) begin
          state_next = (stat.op == OP_LOAD) ? S_LD_END : S_DONE;
        end else begin
          state_next = S_LK_RD;
        end
      end
      S_LD_END:   state_next = S_DONE;
      S_BLD_INIT: state_next = stat.cnt_one ? S_ASG_ROOT : S_SC_RD;
      S_SC_RD:    state_next = S_SC_CHK;
      S_SC_CHK:   state_next = stat.node_last ? S_POP : S_SC_RD;
      S_POP: begin
        if (!stat.first && stat.merge_last) begin
          state_next = S_ASG_ROOT;
        end else begin
          state_next = S_SC_RD;
        end
      end
      S_ASG_ROOT: state_next = stat.cnt_one ? S_FIN : S_ASG_RD;
      S_ASG_RD:   state_next = S_ASG_C0;
      S_ASG_C0:   state_next = S_ASG_C1;
      S_ASG_C1:   state_next = stat.asg_last ? S_FIN : S_ASG_RD;
      S_FIN:      state_next = S_DONE;
      S_DONE:     if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_kind = RES_OK;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DISPATCH: begin
        if (stat.op == OP_BUILD && stat.cnt_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NOT_BUILT;
        end else if ((stat.op == OP_ENCODE || stat.op == OP_DECODE) && !stat.built) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_NOT_BUILT;
        end
      end
      S_LK_CHK: begin
        cmd.lk_chk = 1'b1;
        if (stat.lk_match) begin
          cmd.res_load = 1'b1;
          unique case (stat.op)
            OP_LOAD: begin
              cmd.ld_update = 1'b1;
              cmd.res_kind  = RES_OK;
            end
            OP_ENCODE: cmd.res_kind = RES_CODE;
            default: begin
              cmd.res_kind = RES_SYM;
              cmd.acc_clr  = 1'b1;
            end
          endcase
        end else if (stat.leaf_last) begin
          if (stat.op == OP_ENCODE) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_UNKNOWN;
          end else if (stat.op == OP_DECODE) begin
            cmd.res_load = 1'b1;
            if (stat.prefix_any) begin
              cmd.res_kind = RES_OK;
            end else begin
              cmd.res_kind = RES_INVALID;
              cmd.acc_clr  = 1'b1;
            end
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LD_END: begin
        cmd.res_load = 1'b1;
        if (stat.cnt_full) begin
          cmd.res_kind = RES_FULL;
        end else begin
          cmd.ld_append = 1'b1;
          cmd.res_kind  = RES_OK;
        end
      end
      S_BLD_INIT: cmd.bld_init = 1'b1;
      S_SC_CHK: begin
        cmd.scan_chk = 1'b1;
        cmd.idx_inc  = !stat.node_last;
      end
      S_POP:      cmd.pop = 1'b1;
      S_ASG_ROOT: cmd.asg_root = 1'b1;
      S_ASG_C0:   cmd.asg_c0 = 1'b1;
      S_ASG_C1: begin
        cmd.asg_c1  = 1'b1;
        cmd.idx_dec = !stat.asg_last;
      end
      S_FIN: begin
        cmd.bld_finish = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_kind   = RES_OK;
      end
      S_DONE:     cmd.out_push = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

[hdl/huffman_codebook_codec.sv]
// The time from the accepting edge to the edge that raises m_tvalid grows with the leaf k of n
// at which a load, an encode or a decode stops (k = n when no leaf matches); a load of a new
// symbol also passes through S_LD_END, a not-built answer or an empty build goes from dispatch
// straight to done, and a build of n symbols grows with n; any stall on the output side adds.
// Throughput: one word at a time; the next word is taken once the current result is registered.
// Reset (rst, synchronous, active high) clears the table, built flag, accumulator and output.
module huffman_codebook_codec (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // symbol_value [7:0], weight [23:8], code_bit [24], zero fill above.
  input  logic [hcc_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation [1:0].
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status [2:0], decoded_symbol [10:3], codeword [41:11], codeword_length [46:42], zero fill.
  output logic [hcc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import hcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each operation: a leaf search for load, encode and decode,
  // and for a build the repeated lowest-weight scans, the merges and then a walk from the
  // root down that hands each child its parent's code with one more bit appended.
  hcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the symbol, weight, child and code stores, the decode accumulator
  // and the output register, so a finished result waits there while a new word comes in.
  hcc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
